// ===== rtl/gwwh_pkg.sv =====
// ----------------------------------------------------------------------------
// gwwh_pkg
// shared sizes, register indexes and control types of the grid histogrammer
// ----------------------------------------------------------------------------
package gwwh_pkg;

	// grid shape
	localparam int NUM_FOILS   = 10;
	localparam int NUM_ROWS    = 13;
	localparam int NUM_COLUMNS = 19;

	localparam int DEPTH  = NUM_FOILS * NUM_ROWS * NUM_COLUMNS;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	// longest axis sets the scan length
	localparam int MAX_FR = (NUM_FOILS > NUM_ROWS) ? NUM_FOILS : NUM_ROWS;
	localparam int MAX_N  = (MAX_FR > NUM_COLUMNS) ? MAX_FR : NUM_COLUMNS;

	localparam int HALF_ROWS    = (NUM_ROWS - 1) / 2;
	localparam int HALF_COLUMNS = (NUM_COLUMNS - 1) / 2;

	// field widths
	localparam int IDX_W    = 6;
	localparam int POS_IN_W = 21;
	localparam int POS_W    = 28;
	localparam int WIN_W    = 17;
	localparam int PITCH_W  = 18;
	localparam int STEP_W   = 20;
	localparam int WEIGHT_W = 32;
	localparam int BIN_W    = 48;

	localparam logic [BIN_W-1:0] BIN_MAX = '1;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 21;

	localparam logic [CFG_IDX_W-1:0] REG_FOIL_FIRST_Z = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FOIL_SPACING = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FOIL_WINDOW  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_PITCH    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_COLUMN_PITCH = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_HOLE_WINDOW  = 3'd5;

	typedef struct packed {
		logic             load;
		logic             step;
		logic [IDX_W-1:0] idx;
	} axis_ctrl_t;

	typedef struct packed {
		logic             hit;
		logic [IDX_W-1:0] idx;
	} axis_hit_t;

endpackage

// ===== rtl/gwwh_axis.sv =====
// ----------------------------------------------------------------------------
// gwwh_axis
// one-centre-per-cycle window match along a single axis, highest index kept
// ----------------------------------------------------------------------------
module gwwh_axis (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  gwwh_pkg::axis_ctrl_t                   ctrl,
	input  logic signed [gwwh_pkg::POS_W-1:0]      base,
	input  logic signed [gwwh_pkg::POS_W-1:0]      step,
	input  logic        [gwwh_pkg::WIN_W-1:0]      window,
	input  logic        [gwwh_pkg::IDX_W-1:0]      limit,
	input  logic signed [gwwh_pkg::POS_W-1:0]      pos,
	output gwwh_pkg::axis_hit_t                    found
);
	import gwwh_pkg::*;

	logic signed [POS_W-1:0] centre_q;
	logic                    hit_q;
	logic [IDX_W-1:0]        idx_q;

	logic signed [POS_W:0]   diff;
	logic        [POS_W:0]   mag;
	logic                    in_win;

	always_comb begin
		diff   = {pos[POS_W-1], pos} - {centre_q[POS_W-1], centre_q};
		mag    = diff[POS_W] ? (POS_W+1)'(-diff) : diff;
		in_win = (mag < (POS_W+1)'(window)) && (ctrl.idx < limit);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (ctrl.load) begin
			hit_q <= 1'b0;
		end else if (ctrl.step && in_win) begin
			hit_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			centre_q <= base;
		end else if (ctrl.step) begin
			centre_q <= centre_q + step;
			if (in_win) begin
				idx_q <= ctrl.idx;
			end
		end
	end

	assign found.hit = hit_q;
	assign found.idx = idx_q;

endmodule

// ===== rtl/grid_window_weighted_histogram.sv =====
// ----------------------------------------------------------------------------
// grid_window_weighted_histogram
// weighted event histogram over a foil / row / column grid held in one ram
// ----------------------------------------------------------------------------
//
//  channel   direction  transfer when               carries
//  -------   ---------  -------------------------   ------------------------------
//  command   in         start && !busy              cmd, positions, weight, read idx
//  config    in         cfg_valid && cfg_ready      cfg_index, cfg_data
//  result    out        done (one cycle, no stall)  matched, indices, bin_total, sat
//
//  a bin event holds busy while the three axes share one centre counter, one centre
//  per cycle, then through a ram read state and a modify/write state; an event that
//  misses skips the write
//  a read command holds busy through the read and output states, the read state only
//  when an index is out of range; done comes in the first idle cycle after busy drops
//  after reset the bin ram is swept to zero, one bin a cycle, with busy high;
//  configuration writes are taken at any time, cfg_ready is always high
//  the result receiver cannot stall: done is a single-cycle strobe
//
module grid_window_weighted_histogram (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// command channel
	input  logic                                   start,
	output logic                                   busy,
	input  logic                                   cmd,
	input  logic signed [gwwh_pkg::POS_IN_W-1:0]   target_z,
	input  logic signed [gwwh_pkg::POS_IN_W-1:0]   sieve_y,
	input  logic signed [gwwh_pkg::POS_IN_W-1:0]   sieve_x,
	input  logic        [gwwh_pkg::WEIGHT_W-1:0]   event_weight,
	input  logic        [3:0]                      read_foil,
	input  logic        [3:0]                      read_row,
	input  logic        [4:0]                      read_column,
	// configuration channel
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic        [gwwh_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic        [gwwh_pkg::CFG_DATA_W-1:0] cfg_data,
	// result channel
	output logic                                   done,
	output logic                                   matched,
	output logic        [3:0]                      foil_index,
	output logic        [3:0]                      row_index,
	output logic        [4:0]                      column_index,
	output logic        [gwwh_pkg::BIN_W-1:0]      bin_total,
	output logic                                   saturated
);
	import gwwh_pkg::*;

	// sequencer codes
	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_SCAN  = 3'd2;
	localparam logic [2:0] ST_ADDR  = 3'd3;
	localparam logic [2:0] ST_MOD   = 3'd4;

	logic [2:0] state_q;
	logic [ADDR_W-1:0] clr_q;
	logic [IDX_W-1:0]  scan_q;

	// configuration registers
	logic signed [POS_IN_W-1:0] foil_first_z_q;
	logic signed [STEP_W-1:0]   foil_spacing_q;
	logic        [WIN_W-1:0]    foil_window_q;
	logic        [PITCH_W-1:0]  row_pitch_q;
	logic        [PITCH_W-1:0]  column_pitch_q;
	logic        [WIN_W-1:0]    hole_window_q;

	// latched command
	logic                       cmd_q;
	logic signed [POS_IN_W-1:0] z_q, y_q, x_q;
	logic        [WEIGHT_W-1:0] weight_q;
	logic        [IDX_W-1:0]    rd_f_q, rd_r_q, rd_c_q;

	// bin selected for the ram access
	logic [IDX_W-1:0]  f_q, r_q, c_q;
	logic [ADDR_W-1:0] addr_q;

	// result registers
	logic              done_q;
	logic              matched_q;
	logic [3:0]        foil_q, row_q;
	logic [4:0]        col_q;
	logic [BIN_W-1:0]  total_q;
	logic              sat_q;

	// bin ram
	logic [BIN_W-1:0]  bin_mem [DEPTH];
	logic [BIN_W-1:0]  rdata_q;
	logic              mem_we, mem_re;
	logic [ADDR_W-1:0] mem_waddr;
	logic [BIN_W-1:0]  mem_wdata;

	logic accept;
	axis_ctrl_t axis_ctrl;
	axis_hit_t  hit_z, hit_y, hit_x;

	logic signed [POS_W-1:0] z_base, y_base, x_base;
	logic signed [POS_W-1:0] z_step, y_step, x_step;

	logic [IDX_W-1:0]  sel_f, sel_r, sel_c;
	logic              sel_ok;
	logic [ADDR_W-1:0] sel_addr;
	logic [BIN_W:0]    sum;
	logic [BIN_W-1:0]  new_total;

	assign busy      = (state_q != ST_IDLE);
	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;

	// configuration writes, index beyond the list is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foil_first_z_q <= 21'sd200000;
			foil_spacing_q <= -20'sd50000;
			foil_window_q  <= 17'd10000;
			row_pitch_q    <= 18'd22225;
			column_pitch_q <= 18'd31750;
			hole_window_q  <= 17'd5000;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_FOIL_FIRST_Z: foil_first_z_q <= cfg_data[POS_IN_W-1:0];
				REG_FOIL_SPACING: foil_spacing_q <= cfg_data[STEP_W-1:0];
				REG_FOIL_WINDOW:  foil_window_q  <= cfg_data[WIN_W-1:0];
				REG_ROW_PITCH:    row_pitch_q    <= cfg_data[PITCH_W-1:0];
				REG_COLUMN_PITCH: column_pitch_q <= cfg_data[PITCH_W-1:0];
				REG_HOLE_WINDOW:  hole_window_q  <= cfg_data[WIN_W-1:0];
				default: ;
			endcase
		end
	end

	// first centre of each axis; rows and columns are centred on zero
	always_comb begin
		z_base = POS_W'(foil_first_z_q);
		z_step = POS_W'(foil_spacing_q);
		y_step = POS_W'(row_pitch_q);
		x_step = POS_W'(column_pitch_q);
		y_base = POS_W'(0) - POS_W'(POS_W'(HALF_ROWS) * POS_W'(row_pitch_q));
		x_base = POS_W'(0) - POS_W'(POS_W'(HALF_COLUMNS) * POS_W'(column_pitch_q));
	end

	always_comb begin
		axis_ctrl.load = accept && !cmd;
		axis_ctrl.step = (state_q == ST_SCAN);
		axis_ctrl.idx  = scan_q;
	end

	gwwh_axis u_axis_z (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (axis_ctrl),
		.base   (z_base),
		.step   (z_step),
		.window (foil_window_q),
		.limit  (IDX_W'(NUM_FOILS)),
		.pos    (POS_W'(z_q)),
		.found  (hit_z)
	);

	gwwh_axis u_axis_y (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (axis_ctrl),
		.base   (y_base),
		.step   (y_step),
		.window (hole_window_q),
		.limit  (IDX_W'(NUM_ROWS)),
		.pos    (POS_W'(y_q)),
		.found  (hit_y)
	);

	gwwh_axis u_axis_x (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (axis_ctrl),
		.base   (x_base),
		.step   (x_step),
		.window (hole_window_q),
		.limit  (IDX_W'(NUM_COLUMNS)),
		.pos    (POS_W'(x_q)),
		.found  (hit_x)
	);

	// bin selection: requested indices for a read, matched indices for an event
	always_comb begin
		sel_f = cmd_q ? rd_f_q : hit_z.idx;
		sel_r = cmd_q ? rd_r_q : hit_y.idx;
		sel_c = cmd_q ? rd_c_q : hit_x.idx;
		if (cmd_q) begin
			sel_ok = (rd_f_q < IDX_W'(NUM_FOILS)) && (rd_r_q < IDX_W'(NUM_ROWS))
				&& (rd_c_q < IDX_W'(NUM_COLUMNS));
		end else begin
			sel_ok = hit_z.hit && hit_y.hit && hit_x.hit;
		end
		sel_addr = ADDR_W'(ADDR_W'(ADDR_W'(sel_f) * ADDR_W'(NUM_ROWS) + ADDR_W'(sel_r))
			* ADDR_W'(NUM_COLUMNS) + ADDR_W'(sel_c));
	end

	// saturating accumulate
	always_comb begin
		sum       = {1'b0, rdata_q} + (BIN_W+1)'(weight_q);
		new_total = sum[BIN_W] ? BIN_MAX : sum[BIN_W-1:0];
	end

	// ram port use: clearing sweep or write-back of the updated bin, and the bin read
	always_comb begin
		mem_we    = (state_q == ST_CLEAR) || ((state_q == ST_MOD) && !cmd_q);
		mem_waddr = (state_q == ST_CLEAR) ? clr_q : addr_q;
		mem_wdata = (state_q == ST_CLEAR) ? '0 : new_total;
		mem_re    = (state_q == ST_ADDR) && sel_ok;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			bin_mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= bin_mem[sel_addr];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			scan_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			// strobe after the output cycle, or straight from addressing when no bin is used
			done_q <= (state_q == ST_MOD) || ((state_q == ST_ADDR) && !sel_ok);
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + ADDR_W'(1);
					if (clr_q == ADDR_W'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						scan_q  <= '0;
						state_q <= cmd ? ST_ADDR : ST_SCAN;
					end
				end
				ST_SCAN: begin
					scan_q <= scan_q + IDX_W'(1);
					if (scan_q == IDX_W'(MAX_N - 1)) begin
						state_q <= ST_ADDR;
					end
				end
				ST_ADDR: begin
					if (sel_ok) begin
						state_q <= ST_MOD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_MOD: begin
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// command latch
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q    <= cmd;
			z_q      <= target_z;
			y_q      <= sieve_y;
			x_q      <= sieve_x;
			weight_q <= event_weight;
			rd_f_q   <= IDX_W'(read_foil);
			rd_r_q   <= IDX_W'(read_row);
			rd_c_q   <= IDX_W'(read_column);
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (state_q == ST_ADDR) begin
			f_q    <= sel_f;
			r_q    <= sel_r;
			c_q    <= sel_c;
			addr_q <= sel_addr;
			if (!sel_ok) begin
				// no bin touched: a read echoes its indices, a missed event shows zeros
				matched_q <= 1'b0;
				foil_q    <= cmd_q ? sel_f[3:0] : 4'd0;
				row_q     <= cmd_q ? sel_r[3:0] : 4'd0;
				col_q     <= cmd_q ? sel_c[4:0] : 5'd0;
				total_q   <= '0;
				sat_q     <= 1'b0;
			end
		end else if (state_q == ST_MOD) begin
			matched_q <= !cmd_q;
			foil_q    <= f_q[3:0];
			row_q     <= r_q[3:0];
			col_q     <= c_q[4:0];
			total_q   <= cmd_q ? rdata_q : new_total;
			sat_q     <= cmd_q ? (rdata_q == BIN_MAX) : (new_total == BIN_MAX);
		end
	end

	assign done         = done_q;
	assign matched      = matched_q;
	assign foil_index   = foil_q;
	assign row_index    = row_q;
	assign column_index = col_q;
	assign bin_total    = total_q;
	assign saturated    = sat_q;

endmodule

// ===== tb/sv/histogram_tb_pkg.sv =====
// ----------------------------------------------------------------------------
// histogram_tb_pkg
// command codes and spare register indexes shared by the histogram testbench
// ----------------------------------------------------------------------------
package histogram_tb_pkg;

	typedef enum logic {
		CMD_BIN  = 1'b0,
		CMD_READ = 1'b1
	} command_t;

	// indexes past the register list, writes there are dropped
	localparam logic [2:0] REG_SPARE_6 = 3'd6;
	localparam logic [2:0] REG_SPARE_7 = 3'd7;

endpackage

// ===== tb/sv/histogram_checker.sv =====
// ----------------------------------------------------------------------------
// histogram_checker
// watches the command, config and result channels of the grid histogrammer,
// keeps its own bin totals and register copy, and checks every result strobe
// ----------------------------------------------------------------------------
module histogram_checker (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	input  logic                                   busy,
	input  logic                                   cmd,
	input  logic signed [gwwh_pkg::POS_IN_W-1:0]   target_z,
	input  logic signed [gwwh_pkg::POS_IN_W-1:0]   sieve_y,
	input  logic signed [gwwh_pkg::POS_IN_W-1:0]   sieve_x,
	input  logic        [gwwh_pkg::WEIGHT_W-1:0]   event_weight,
	input  logic        [3:0]                      read_foil,
	input  logic        [3:0]                      read_row,
	input  logic        [4:0]                      read_column,
	input  logic                                   cfg_valid,
	input  logic                                   cfg_ready,
	input  logic        [gwwh_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic        [gwwh_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                                   done,
	input  logic                                   matched,
	input  logic        [3:0]                      foil_index,
	input  logic        [3:0]                      row_index,
	input  logic        [4:0]                      column_index,
	input  logic        [gwwh_pkg::BIN_W-1:0]      bin_total,
	input  logic                                   saturated,
	output int                                     errors,
	output int                                     outstanding,
	output int                                     event_count,
	output int                                     hit_count,
	output int                                     read_count
);
	import gwwh_pkg::*;
	import histogram_tb_pkg::*;

	typedef struct packed {
		logic             matched;
		logic [3:0]       foil;
		logic [3:0]       row;
		logic [4:0]       column;
		logic [BIN_W-1:0] total;
		logic             saturated;
	} bin_result_t;

	logic [BIN_W-1:0] bin_totals [NUM_FOILS][NUM_ROWS][NUM_COLUMNS];
	bin_result_t      pending_results [$];

	longint first_z, spacing, foil_win, row_pitch, col_pitch, hole_win;

	// highest centre index inside the strict window, or -1
	function automatic int highest_centre_hit(longint pos, longint base, longint pitch,
			int count, longint win);
		int     found = -1;
		longint d;
		for (int i = 0; i < count; i++) begin
			d = pos - (base + i * pitch);
			if (d < 0)
				d = -d;
			if (d < win)
				found = i;
		end
		return found;
	endfunction

	// outcome of one command, bin totals updated on a hit
	function automatic bin_result_t bin_outcome(logic op, longint z, longint y, longint x,
			logic [WEIGHT_W-1:0] w, logic [3:0] rf, logic [3:0] rr, logic [4:0] rc);
		bin_result_t res;
		int          fi, ri, ci;
		res = '0;
		if (op == CMD_READ) begin
			res.foil   = rf;
			res.row    = rr;
			res.column = rc;
			if (rf < NUM_FOILS && rr < NUM_ROWS && rc < NUM_COLUMNS)
				res.total = bin_totals[rf][rr][rc];
		end else begin
			fi = highest_centre_hit(z, first_z, spacing, NUM_FOILS, foil_win);
			ri = highest_centre_hit(y, -HALF_ROWS * row_pitch, row_pitch, NUM_ROWS, hole_win);
			ci = highest_centre_hit(x, -HALF_COLUMNS * col_pitch, col_pitch, NUM_COLUMNS,
				hole_win);
			if (fi >= 0 && ri >= 0 && ci >= 0) begin
				if (bin_totals[fi][ri][ci] > BIN_MAX - w)
					bin_totals[fi][ri][ci] = BIN_MAX;
				else
					bin_totals[fi][ri][ci] = bin_totals[fi][ri][ci] + w;
				res.matched = 1'b1;
				res.foil    = 4'(fi);
				res.row     = 4'(ri);
				res.column  = 5'(ci);
				res.total   = bin_totals[fi][ri][ci];
			end
		end
		res.saturated = (res.total == BIN_MAX);
		return res;
	endfunction

	task automatic compare_field(string field, longint unsigned want, longint unsigned seen);
		if (want != seen) begin
			errors++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, seen);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		bin_result_t want;
		if (!arst_n) begin
			for (int f = 0; f < NUM_FOILS; f++)
				for (int r = 0; r < NUM_ROWS; r++)
					for (int c = 0; c < NUM_COLUMNS; c++)
						bin_totals[f][r][c] = '0;
			// register values after reset
			first_z   = 200000;
			spacing   = -50000;
			foil_win  = 10000;
			row_pitch = 22225;
			col_pitch = 31750;
			hole_win  = 5000;
			pending_results.delete();
			errors      = 0;
			event_count = 0;
			hit_count   = 0;
			read_count  = 0;
		end else begin
			if (done) begin
				if (pending_results.size() == 0) begin
					errors++;
					$display("%0t: result strobe with no command waiting for it", $time);
				end else begin
					want = pending_results.pop_front();
					compare_field("matched", want.matched, matched);
					compare_field("foil_index", want.foil, foil_index);
					compare_field("row_index", want.row, row_index);
					compare_field("column_index", want.column, column_index);
					compare_field("bin_total", want.total, bin_total);
					compare_field("saturated", want.saturated, saturated);
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_FOIL_FIRST_Z: first_z   = longint'($signed(cfg_data[20:0]));
					REG_FOIL_SPACING: spacing   = longint'($signed(cfg_data[19:0]));
					REG_FOIL_WINDOW:  foil_win  = longint'(cfg_data[16:0]);
					REG_ROW_PITCH:    row_pitch = longint'(cfg_data[17:0]);
					REG_COLUMN_PITCH: col_pitch = longint'(cfg_data[17:0]);
					REG_HOLE_WINDOW:  hole_win  = longint'(cfg_data[16:0]);
					default: ;
				endcase
			end
			if (start && !busy) begin
				want = bin_outcome(cmd, longint'(target_z), longint'(sieve_y),
					longint'(sieve_x), event_weight, read_foil, read_row, read_column);
				// queue at the tail, results come back in command order
				pending_results.insert(pending_results.size(), want);
				if (cmd == CMD_READ)
					read_count++;
				else
					event_count++;
				if (want.matched)
					hit_count++;
			end
		end
		outstanding = pending_results.size();
	end

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// stimulus and verdict for the grid histogrammer: walks a set of grid settings
// from zero windows to the widest pitches, fires aimed, edge and noise events
// plus bin reads in random bursts, and leaves checking to histogram_checker
// ----------------------------------------------------------------------------
module tb;
	import gwwh_pkg::*;
	import histogram_tb_pkg::*;

	localparam int NUM_SETTINGS     = 7;
	localparam int RANDOM_PER_PHASE = 260;
	localparam int POS_LIMIT        = 1000000;

	logic                       clk, arst_n;
	logic                       start, busy, cmd;
	logic signed [POS_IN_W-1:0] target_z, sieve_y, sieve_x;
	logic [WEIGHT_W-1:0]        event_weight;
	logic [3:0]                 read_foil, read_row;
	logic [4:0]                 read_column;
	logic                       cfg_valid, cfg_ready;
	logic [CFG_IDX_W-1:0]       cfg_index;
	logic [CFG_DATA_W-1:0]      cfg_data;
	logic                       done, matched, saturated;
	logic [3:0]                 foil_index, row_index;
	logic [4:0]                 column_index;
	logic [BIN_W-1:0]           bin_total;
	int                         errors, outstanding, event_count, hit_count, read_count;

	// grid as last written, used only to aim events at bin centres
	longint grid_first_z, grid_spacing, grid_foil_win;
	longint grid_row_pitch, grid_col_pitch, grid_hole_win;
	// bin of the last aimed event, so reads often land on filled bins
	int     aimed_foil, aimed_row, aimed_column;

	grid_window_weighted_histogram dut (.*);

	histogram_checker chk (.*);

	// free-running clock, period 8
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// hard stop well beyond the slowest legal run
	initial begin
		#(8 * 500000);
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic longint rand_pos();
		return longint'($urandom_range(0, 2 * POS_LIMIT)) - POS_LIMIT;
	endfunction

	// position near a centre: well inside, on the last inside step, on the window
	// edge itself, just past it or on the centre itself; clipped to the field range
	function automatic longint aim(longint centre, longint win);
		longint pos;
		longint sgn;
		int     mode;
		mode = $urandom_range(0, 9);
		sgn  = $urandom_range(0, 1) ? 1 : -1;
		if (mode < 6 && win > 0)
			pos = centre + longint'($urandom_range(0, 32'(2 * win - 2))) - (win - 1);
		else if (mode == 6 && win > 0)
			pos = centre + sgn * (win - 1);
		else if (mode == 7)
			pos = centre + sgn * win;
		else if (mode == 8)
			pos = centre + sgn * (win + 1);
		else
			pos = centre;
		if (pos > POS_LIMIT)
			pos = POS_LIMIT;
		if (pos < -POS_LIMIT)
			pos = -POS_LIMIT;
		return pos;
	endfunction

	// zero and full scale weights show up often, the rest anywhere
	function automatic logic [WEIGHT_W-1:0] pick_weight();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			2:       return WEIGHT_W'($urandom_range(1, 255));
			default: return WEIGHT_W'($urandom);
		endcase
	endfunction

	// command transfer: start held until taken while busy is low;
	// returns on the following falling edge with start still high
	task automatic send_item(command_t op, longint z, longint y, longint x,
			logic [WEIGHT_W-1:0] w, logic [3:0] rf, logic [3:0] rr, logic [4:0] rc);
		start        = 1'b1;
		cmd          = op;
		target_z     = POS_IN_W'(z);
		sieve_y      = POS_IN_W'(y);
		sieve_x      = POS_IN_W'(x);
		event_weight = w;
		read_foil    = rf;
		read_row     = rr;
		read_column  = rc;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		@(negedge clk);
	endtask

	// bin event, read fields filled with junk
	task automatic send_event(longint z, longint y, longint x, logic [WEIGHT_W-1:0] w);
		send_item(CMD_BIN, z, y, x, w, 4'($urandom), 4'($urandom), 5'($urandom));
	endtask

	// bin read, event fields filled with junk
	task automatic send_read(logic [3:0] rf, logic [3:0] rr, logic [4:0] rc);
		send_item(CMD_READ, rand_pos(), rand_pos(), rand_pos(), WEIGHT_W'($urandom),
			rf, rr, rc);
	endtask

	// register write; bits above the register width carry junk
	task automatic write_register(logic [CFG_IDX_W-1:0] idx, longint value, int width);
		logic [CFG_DATA_W-1:0] keep;
		keep      = (CFG_DATA_W'(1) << width) - 1'b1;
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = (CFG_DATA_W'($urandom) & ~keep) | (CFG_DATA_W'(value) & keep);
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// hold off until every expected result has come and the block is idle
	task automatic drain();
		start = 1'b0;
		while (outstanding != 0 || busy)
			@(negedge clk);
	endtask

	initial begin
		int pick, f, r, c;
		int burst_left;

		// every input known from time zero, reset held low at the start
		arst_n       = 1'b0;
		start        = 1'b0;
		cmd          = CMD_BIN;
		target_z     = '0;
		sieve_y      = '0;
		sieve_x      = '0;
		event_weight = '0;
		read_foil    = '0;
		read_row     = '0;
		read_column  = '0;
		cfg_valid    = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		aimed_foil   = 0;
		aimed_row    = 0;
		aimed_column = 0;
		burst_left   = 1;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		for (int p = 0; p < NUM_SETTINGS; p++) begin
			// registers change only with the block idle
			drain();
			case (p)
				0: begin
					// reset values, written back explicitly
					grid_first_z = 200000;   grid_spacing   = -50000;
					grid_foil_win = 10000;   grid_row_pitch = 22225;
					grid_col_pitch = 31750;  grid_hole_win  = 5000;
				end
				1: begin
					// widest windows and pitches, most negative first foil
					grid_first_z = -1000000; grid_spacing   = 500000;
					grid_foil_win = 100000;  grid_row_pitch = 200000;
					grid_col_pitch = 200000; grid_hole_win  = 100000;
				end
				2: begin
					// zero windows never match, reads still answer
					grid_first_z = 1000000;  grid_spacing   = -500000;
					grid_foil_win = 0;       grid_row_pitch = 0;
					grid_col_pitch = 0;      grid_hole_win  = 0;
				end
				3: begin
					// all centres stacked at zero, exact hit only: top index wins
					grid_first_z = 0;        grid_spacing   = 0;
					grid_foil_win = 1;       grid_row_pitch = 0;
					grid_col_pitch = 0;      grid_hole_win  = 1;
				end
				4: begin
					// windows wider than half a pitch, several centres match
					grid_first_z = 12345;    grid_spacing   = 7000;
					grid_foil_win = 20000;   grid_row_pitch = 3000;
					grid_col_pitch = 4000;   grid_hole_win  = 5000;
				end
				default: begin
					grid_first_z   = longint'($urandom_range(0, 2000000)) - 1000000;
					grid_spacing   = longint'($urandom_range(0, 1000000)) - 500000;
					grid_foil_win  = $urandom_range(0, 100000);
					grid_row_pitch = $urandom_range(0, 200000);
					grid_col_pitch = $urandom_range(0, 200000);
					grid_hole_win  = $urandom_range(0, 100000);
				end
			endcase
			write_register(REG_FOIL_FIRST_Z, grid_first_z, 21);
			write_register(REG_FOIL_SPACING, grid_spacing, 20);
			write_register(REG_FOIL_WINDOW, grid_foil_win, 17);
			write_register(REG_ROW_PITCH, grid_row_pitch, 18);
			write_register(REG_COLUMN_PITCH, grid_col_pitch, 18);
			write_register(REG_HOLE_WINDOW, grid_hole_win, 17);
			// writes past the list must leave every register alone
			write_register(REG_SPARE_6, 0, 0);
			write_register(REG_SPARE_7, 0, 0);

			if (p == 0) begin
				// corner bin twice at full weight, then read back
				send_event(200000, -133350, -285750, '1);
				send_event(200000, -133350, -285750, '1);
				send_read(4'd0, 4'd0, 5'd0);
				// far corner bin with zero weight still reports a hit
				send_event(-250000, 133350, 285750, '0);
				// one step inside each window edge
				send_event(209999, -138349, -280751, 32'd1);
				// exactly on the z, y and x window edges: strict, so a miss
				send_event(210000, -133350, -285750, 32'd5);
				send_event(200000, -128350, -285750, 32'd5);
				send_event(200000, -133350, -290750, 32'd5);
				// field extremes, far from any centre
				send_event(-1000000, -1000000, -1000000, '1);
				send_event(1000000, 1000000, 1000000, '1);
				// midway between two foils
				send_event(175000, 0, 0, 32'd7);
				send_read(4'd9, 4'd12, 5'd18);
				// one index past each axis, then all index bits set
				send_read(4'd10, 4'd0, 5'd0);
				send_read(4'd0, 4'd13, 5'd0);
				send_read(4'd0, 4'd0, 5'd19);
				send_read(4'd15, 4'd15, 5'd31);
				send_read(4'd0, 4'd0, 5'd0);
				// centre bin, row and column centres at zero
				send_event(-50000, 0, 0, pick_weight());
			end

			for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
				// one full stop mid-run with nothing left in flight
				if (p == 0 && n == RANDOM_PER_PHASE / 2)
					drain();
				pick = $urandom_range(0, 99);
				f    = $urandom_range(0, NUM_FOILS - 1);
				r    = $urandom_range(0, NUM_ROWS - 1);
				c    = $urandom_range(0, NUM_COLUMNS - 1);
				if (pick < 60) begin
					// event aimed at one bin, offset around its window edges
					aimed_foil   = f;
					aimed_row    = r;
					aimed_column = c;
					send_event(aim(grid_first_z + f * grid_spacing, grid_foil_win),
						aim((r - HALF_ROWS) * grid_row_pitch, grid_hole_win),
						aim((c - HALF_COLUMNS) * grid_col_pitch, grid_hole_win),
						pick_weight());
				end else if (pick < 78) begin
					// noise: each axis either aimed or anywhere
					send_event($urandom_range(0, 1) ?
							aim(grid_first_z + f * grid_spacing, grid_foil_win) : rand_pos(),
						$urandom_range(0, 1) ?
							aim((r - HALF_ROWS) * grid_row_pitch, grid_hole_win) : rand_pos(),
						$urandom_range(0, 1) ?
							aim((c - HALF_COLUMNS) * grid_col_pitch, grid_hole_win) : rand_pos(),
						pick_weight());
				end else if (pick < 92) begin
					// read back a bin that has likely been filled, or any legal bin
					if ($urandom_range(0, 1))
						send_read(4'(aimed_foil), 4'(aimed_row), 5'(aimed_column));
					else
						send_read(4'(f), 4'(r), 5'(c));
				end else begin
					// any index value, out of range ones included
					send_read(4'($urandom), 4'($urandom), 5'($urandom));
				end

				// bursts of back-to-back commands with short or long gaps
				burst_left--;
				if (burst_left <= 0) begin
					start = 1'b0;
					if ($urandom_range(0, 3) == 0)
						repeat ($urandom_range(10, 40)) @(negedge clk);
					else
						repeat ($urandom_range(1, 5)) @(negedge clk);
					burst_left = $urandom_range(1, 30);
				end
			end
		end

		// let the last results arrive, then a margin for stray strobes
		drain();
		repeat (2 * MAX_N + 10) @(negedge clk);

		$display("run covered %0d bin events (%0d landed in a bin) and %0d bin reads",
			event_count, hit_count, read_count);
		$display("over %0d grid settings, zero windows and stacked centres among them",
			NUM_SETTINGS);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
